>>> rtl/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Types and constants shared by the alert, takeover and lock controller.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int unsigned MS_PER_S_W = 10;
    localparam logic [MS_PER_S_W-1:0] MS_PER_S = 10'd1000;

    localparam logic [15:0] DEFAULT_DURATION_RESET = 16'd60;

    typedef enum logic [2:0] {
        KIND_TICK         = 3'd0,
        KIND_SEND_BEGIN   = 3'd1,
        KIND_SEND_CANCEL  = 3'd2,
        KIND_ALERT_RX     = 3'd3,
        KIND_ALERT_END_RX = 3'd4,
        KIND_GO           = 3'd5,
        KIND_DISMISS      = 3'd6,
        KIND_RELEASE      = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        INTENT_NONE = 2'd0,
        INTENT_SEND = 2'd1,
        INTENT_END  = 2'd2
    } t_intent;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] now_ms;
        logic [15:0] duration_s;
        logic [31:0] sender_id;
        logic        sender_paired;
    } t_atl_in;

    typedef struct packed {
        t_intent     intent;
        logic [15:0] intent_duration_s;
        logic        haptic_alert;
        logic [31:0] locked_id;
    } t_atl_out;

endpackage

>>> rtl/alert_takeover_lock_controller.sv
// ----------------------------------------------------------------------------
// alert_takeover_lock_controller
// Keeps the outgoing alert, pending takeover and sender lock slots with their
// deadlines, and answers every event request with one result request.
// ----------------------------------------------------------------------------
// Each event request is taken into an input register, processed against the slot
// state, and its result is held in an output register until taken. A request is
// accepted every cycle while results keep flowing. Each result passes from the
// input register through the combinational state update into the output
// register. The default send duration may be written only while no request is in
// flight.
module alert_takeover_lock_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  atl_pkg::t_atl_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output atl_pkg::t_atl_out o_out,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data
);
    import atl_pkg::*;

    localparam int unsigned PROD_W = 16 + MS_PER_S_W;

    logic        r_in_valid;
    t_atl_in     r_in;
    logic        r_out_valid;
    t_atl_out    r_out;
    logic [15:0] r_default_dur;

    logic        r_sending, n_sending;
    logic [31:0] r_send_deadline, n_send_deadline;
    logic        r_pending, n_pending;
    logic [31:0] r_pending_sender, n_pending_sender;
    logic [31:0] r_pending_deadline, n_pending_deadline;
    logic [31:0] r_lock_sender, n_lock_sender;
    logic [31:0] r_lock_deadline, n_lock_deadline;

    t_atl_out    n_out;
    logic        advance;
    logic [15:0] dur_eff;
    logic [PROD_W-1:0] dur_ms;
    logic [31:0] new_deadline;
    logic [31:0] send_diff;
    logic [31:0] pending_diff;
    logic [31:0] lock_diff;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A zero duration on send begin falls back to the configured default.
    assign dur_eff = (r_in.kind == KIND_SEND_BEGIN && r_in.duration_s == 16'd0) ?
                     r_default_dur : r_in.duration_s;
    assign dur_ms       = PROD_W'(dur_eff) * PROD_W'(MS_PER_S);
    assign new_deadline = r_in.now_ms + 32'(dur_ms);

    // A deadline counts as reached when bit 31 of (now - deadline) is clear.
    assign send_diff    = r_in.now_ms - r_send_deadline;
    assign pending_diff = r_in.now_ms - r_pending_deadline;
    assign lock_diff    = r_in.now_ms - r_lock_deadline;

    always_comb begin
        n_sending          = r_sending;
        n_send_deadline    = r_send_deadline;
        n_pending          = r_pending;
        n_pending_sender   = r_pending_sender;
        n_pending_deadline = r_pending_deadline;
        n_lock_sender      = r_lock_sender;
        n_lock_deadline    = r_lock_deadline;
        n_out.intent            = INTENT_NONE;
        n_out.intent_duration_s = 16'd0;
        n_out.haptic_alert      = 1'b0;

        case (r_in.kind)
            KIND_TICK: begin
                if (r_sending && !send_diff[31]) begin
                    n_sending       = 1'b0;
                    n_send_deadline = '0;
                    n_out.intent    = INTENT_END;
                end
                if (r_pending && !pending_diff[31]) begin
                    n_pending          = 1'b0;
                    n_pending_sender   = '0;
                    n_pending_deadline = '0;
                end
                if (r_lock_sender != '0 && !lock_diff[31]) begin
                    n_lock_sender   = '0;
                    n_lock_deadline = '0;
                end
            end
            KIND_SEND_BEGIN: begin
                n_sending               = 1'b1;
                n_send_deadline         = new_deadline;
                n_out.intent            = INTENT_SEND;
                n_out.intent_duration_s = dur_eff;
            end
            KIND_SEND_CANCEL: begin
                if (r_sending) begin
                    n_sending       = 1'b0;
                    n_send_deadline = '0;
                    n_out.intent    = INTENT_END;
                end
            end
            KIND_ALERT_RX: begin
                if (r_in.sender_paired) begin
                    n_pending          = 1'b1;
                    n_pending_sender   = r_in.sender_id;
                    n_pending_deadline = new_deadline;
                    n_out.haptic_alert = 1'b1;
                end
            end
            KIND_ALERT_END_RX: begin
                if (r_pending && r_pending_sender == r_in.sender_id) begin
                    n_pending          = 1'b0;
                    n_pending_sender   = '0;
                    n_pending_deadline = '0;
                end
                if (r_lock_sender != '0 && r_lock_sender == r_in.sender_id) begin
                    n_lock_sender   = '0;
                    n_lock_deadline = '0;
                end
            end
            KIND_GO: begin
                if (r_pending) begin
                    n_lock_sender      = r_pending_sender;
                    n_lock_deadline    = r_pending_deadline;
                    n_pending          = 1'b0;
                    n_pending_sender   = '0;
                    n_pending_deadline = '0;
                end
            end
            KIND_DISMISS: begin
                n_pending          = 1'b0;
                n_pending_sender   = '0;
                n_pending_deadline = '0;
            end
            KIND_RELEASE: begin
                n_lock_sender   = '0;
                n_lock_deadline = '0;
            end
            default: begin
                n_lock_sender   = '0;
                n_lock_deadline = '0;
            end
        endcase

        n_out.locked_id = n_lock_sender;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_default_dur      <= DEFAULT_DURATION_RESET;
            r_sending          <= 1'b0;
            r_send_deadline    <= '0;
            r_pending          <= 1'b0;
            r_pending_sender   <= '0;
            r_pending_deadline <= '0;
            r_lock_sender      <= '0;
            r_lock_deadline    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_dur <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid        <= 1'b1;
                r_sending          <= n_sending;
                r_send_deadline    <= n_send_deadline;
                r_pending          <= n_pending;
                r_pending_sender   <= n_pending_sender;
                r_pending_deadline <= n_pending_deadline;
                r_lock_sender      <= n_lock_sender;
                r_lock_deadline    <= n_lock_deadline;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

>>> tb/tb_alert_takeover_lock_controller.sv
// ----------------------------------------------------------------------------
// tb_alert_takeover_lock_controller
// Self-checking bench for the alert, takeover and lock controller. A directed
// opening covers each event kind, the deadline edges and wraparound, and the
// zero default duration. Random traffic with a coherent millisecond clock
// follows, under several default durations and with random stalls on both
// handshakes. Every result is compared against a behavioral copy of the
// slot state.
// ----------------------------------------------------------------------------
module tb_alert_takeover_lock_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import atl_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PHASE_ITEMS   = 220;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned MAX_REPORTS   = 10;

    class slot_tracker;
        bit [15:0]  default_dur = DEFAULT_DURATION_RESET;
        bit         sending;
        bit [31:0]  send_dl;
        bit         pending;
        bit [31:0]  pending_sender;
        bit [31:0]  pending_dl;
        bit [31:0]  lock_sender;
        bit [31:0]  lock_dl;
        t_atl_out   expected_outcomes[$];
        int unsigned fault_count;

        function void set_default(bit [15:0] value);
            default_dur = value;
        endfunction

        function bit [31:0] expiry(bit [31:0] now, bit [15:0] dur);
            return now + 32'(dur) * 32'(MS_PER_S);
        endfunction

        // A deadline counts as reached once the signed difference stops being negative.
        function bit due(bit [31:0] now, bit [31:0] dl);
            bit [31:0] diff;
            diff = now - dl;
            return !diff[31];
        endfunction

        function void drop_pending();
            pending = 1'b0;
            pending_sender = '0;
            pending_dl = '0;
        endfunction

        function void drop_lock();
            lock_sender = '0;
            lock_dl = '0;
        endfunction

        function void note_event(t_atl_in ev);
            t_atl_out  res;
            bit [15:0] dur;
            res.intent = INTENT_NONE;
            res.intent_duration_s = '0;
            res.haptic_alert = 1'b0;
            case (ev.kind)
                KIND_TICK: begin
                    if (sending && due(ev.now_ms, send_dl)) begin
                        sending = 1'b0;
                        send_dl = '0;
                        res.intent = INTENT_END;
                    end
                    if (pending && due(ev.now_ms, pending_dl))
                        drop_pending();
                    if (lock_sender != 0 && due(ev.now_ms, lock_dl))
                        drop_lock();
                end
                KIND_SEND_BEGIN: begin
                    dur = (ev.duration_s == 0) ? default_dur : ev.duration_s;
                    sending = 1'b1;
                    send_dl = expiry(ev.now_ms, dur);
                    res.intent = INTENT_SEND;
                    res.intent_duration_s = dur;
                end
                KIND_SEND_CANCEL: begin
                    if (sending) begin
                        sending = 1'b0;
                        send_dl = '0;
                        res.intent = INTENT_END;
                    end
                end
                KIND_ALERT_RX: begin
                    if (ev.sender_paired) begin
                        pending = 1'b1;
                        pending_sender = ev.sender_id;
                        pending_dl = expiry(ev.now_ms, ev.duration_s);
                        res.haptic_alert = 1'b1;
                    end
                end
                KIND_ALERT_END_RX: begin
                    if (pending && pending_sender == ev.sender_id)
                        drop_pending();
                    if (lock_sender != 0 && lock_sender == ev.sender_id)
                        drop_lock();
                end
                KIND_GO: begin
                    if (pending) begin
                        lock_sender = pending_sender;
                        lock_dl = pending_dl;
                        drop_pending();
                    end
                end
                KIND_DISMISS: drop_pending();
                default: drop_lock();
            endcase
            res.locked_id = lock_sender;
            expected_outcomes.push_back(res);
        endfunction

        function void check_outcome(t_atl_out got);
            t_atl_out want;
            if (expected_outcomes.size() == 0) begin
                if (fault_count < MAX_REPORTS)
                    $display("unexpected result: intent=%0d dur=%0d alert=%0b locked=%h",
                             got.intent, got.intent_duration_s, got.haptic_alert,
                             got.locked_id);
                fault_count++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.intent !== want.intent
                    || got.intent_duration_s !== want.intent_duration_s
                    || got.haptic_alert !== want.haptic_alert
                    || got.locked_id !== want.locked_id) begin
                if (fault_count < MAX_REPORTS) begin
                    $display("mismatch: expected intent=%0d dur=%0d alert=%0b locked=%h",
                             want.intent, want.intent_duration_s, want.haptic_alert,
                             want.locked_id);
                    $display("          got      intent=%0d dur=%0d alert=%0b locked=%h",
                             got.intent, got.intent_duration_s, got.haptic_alert,
                             got.locked_id);
                end
                fault_count++;
            end
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_atl_in     i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_atl_out    o_out;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    slot_tracker    tracker;
    bit             calm;
    bit [31:0]      clock_ms;
    bit [31:0]      id_pool[4];
    int unsigned    cycle_count;

    alert_takeover_lock_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.note_event(i_in);
            if (o_out_valid && i_out_ready)
                tracker.check_outcome(o_out);
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 38);
    end

    function automatic t_atl_in make_req(t_kind kind, bit [31:0] now, bit [15:0] dur,
                                         bit [31:0] sender, bit paired);
        t_atl_in r;
        r.kind = kind;
        r.now_ms = now;
        r.duration_s = dur;
        r.sender_id = sender;
        r.sender_paired = paired;
        return r;
    endfunction

    task automatic push_request(input t_atl_in r);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_default(input bit [15:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        tracker.set_default(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed events on a clock that moves forward, with the unused
    // fields left as random noise; a share of requests is random throughout.
    function automatic t_atl_in random_request();
        t_atl_in     r;
        int unsigned pick;
        r.kind = t_kind'($urandom_range(7));
        r.now_ms = $urandom;
        r.duration_s = 16'($urandom);
        r.sender_id = $urandom;
        r.sender_paired = 1'($urandom);
        if ($urandom_range(99) < 12)
            return r;
        pick = $urandom_range(99);
        if (pick < 30) begin
            r.kind = KIND_TICK;
            if ($urandom_range(99) < 5)
                clock_ms += $urandom;
            else
                clock_ms += $urandom_range(2500);
        end else begin
            clock_ms += $urandom_range(300);
            if (pick < 42)      r.kind = KIND_SEND_BEGIN;
            else if (pick < 50) r.kind = KIND_SEND_CANCEL;
            else if (pick < 68) r.kind = KIND_ALERT_RX;
            else if (pick < 78) r.kind = KIND_ALERT_END_RX;
            else if (pick < 88) r.kind = KIND_GO;
            else if (pick < 94) r.kind = KIND_DISMISS;
            else                r.kind = KIND_RELEASE;
        end
        r.now_ms = clock_ms;
        pick = $urandom_range(99);
        if (pick < 70)      r.duration_s = 16'($urandom_range(5));
        else if (pick < 90) r.duration_s = 16'($urandom_range(120));
        if ($urandom_range(99) < 85)
            r.sender_id = id_pool[2'($urandom_range(3))];
        r.sender_paired = ($urandom_range(99) < 85);
        return r;
    endfunction

    initial begin
        bit [15:0] phase_default[5];
        tracker = new;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        calm = 1'b0;
        cycle_count = 0;
        id_pool[0] = '0;
        for (int i = 1; i < 4; i++) id_pool[2'(i)] = $urandom;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening, default duration still at its reset value.
        push_request(make_req(KIND_TICK, 32'd0, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_SEND_BEGIN, 32'd1000, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_SEND_BEGIN, '1, '1, '1, 1'b1));
        push_request(make_req(KIND_TICK, '1, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_SEND_CANCEL, '1, '1, '1, 1'b1));
        push_request(make_req(KIND_SEND_CANCEL, 32'd0, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_ALERT_RX, 32'd50, 16'd4, '1, 1'b0));
        push_request(make_req(KIND_ALERT_RX, 32'd100, 16'd2, '1, 1'b1));
        push_request(make_req(KIND_ALERT_END_RX, 32'd0, 16'd0, 32'd1234, 1'b0));
        push_request(make_req(KIND_GO, '1, '1, 32'd77, 1'b1));
        // The lock deadline is 2100; reaching it exactly must clear the lock.
        push_request(make_req(KIND_TICK, 32'd2099, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_TICK, 32'd2100, 16'd0, 32'd0, 1'b0));
        // A takeover from sender zero leaves the block unlocked after go.
        push_request(make_req(KIND_ALERT_RX, 32'd0, 16'd1, 32'd0, 1'b1));
        push_request(make_req(KIND_GO, 32'd0, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_ALERT_RX, 32'd10, 16'd3, 32'd5, 1'b1));
        push_request(make_req(KIND_DISMISS, '1, '1, '1, 1'b1));
        push_request(make_req(KIND_GO, 32'd0, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_ALERT_RX, 32'd20, 16'd0, 32'd9, 1'b1));
        push_request(make_req(KIND_ALERT_END_RX, 32'd0, 16'd0, 32'd9, 1'b0));
        push_request(make_req(KIND_ALERT_RX, 32'd30, 16'd8, 32'd9, 1'b1));
        push_request(make_req(KIND_GO, 32'd0, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_ALERT_END_RX, 32'd0, 16'd0, 32'd9, 1'b1));
        push_request(make_req(KIND_ALERT_RX, 32'd40, 16'd8, 32'd7, 1'b1));
        push_request(make_req(KIND_GO, 32'd0, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_RELEASE, '1, '1, '1, 1'b1));
        // The send deadline wraps past the top of the millisecond counter.
        push_request(make_req(KIND_SEND_BEGIN, 32'hFFFF_FC18, 16'd1, 32'd0, 1'b0));
        push_request(make_req(KIND_TICK, '1, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_TICK, 32'd0, 16'd0, 32'd0, 1'b0));

        // With a zero default, a zero-length send ends on the very next tick.
        write_default(16'd0);
        push_request(make_req(KIND_SEND_BEGIN, 32'd123, 16'd0, 32'd0, 1'b0));
        push_request(make_req(KIND_TICK, 32'd123, 16'd0, 32'd0, 1'b0));

        phase_default[0] = 16'd1;
        phase_default[1] = 16'hFFFF;
        phase_default[2] = 16'd0;
        phase_default[3] = 16'($urandom);
        phase_default[4] = DEFAULT_DURATION_RESET;
        for (int p = 0; p < 5; p++) begin
            write_default(phase_default[3'(p)]);
            clock_ms = $urandom;
            if ($urandom_range(1))
                clock_ms = 32'hFFFF_FFFF - $urandom_range(20000);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                calm = (p == 2 && n < 150);
                if (n == PHASE_ITEMS / 2)
                    drain();
                push_request(random_request());
            end
            calm = 1'b0;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.fault_count == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
